// ===== rtl/core/glmf_pkg.sv =====
// Shared types and constants for the grid local maximum finder.
// Holds the record control group, the back-end state type and the
// register indexes; depends on nothing else.
package glmf_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int OUT_ROW_W   = 5;
  localparam int OUT_COL_W   = 5;
  localparam int OUT_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLS = 2'd1;

  typedef logic [1:0] line_t;

  localparam line_t LINE_FIRST = 2'd0;
  localparam line_t LINE_LAST  = 2'd2;

  typedef struct packed {
    logic  decide;
    logic  above;
    logic  flush;
    line_t line;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CEN,
    ST_RD_SIDE,
    ST_DECIDE,
    ST_EMIT,
    ST_FINISH
  } state_t;

  function automatic line_t line_next(line_t l);
    line_t n;
    n = (l == LINE_LAST) ? LINE_FIRST : line_t'(l + 2'd1);
    return n;
  endfunction

  function automatic line_t line_prev(line_t l);
    line_t n;
    n = (l == LINE_FIRST) ? LINE_LAST : line_t'(l - 2'd1);
    return n;
  endfunction

endpackage

// ===== rtl/core/grid_local_maximum_finder.sv =====
// Usage: grid values enter on the in_ stream in raster order; the out_ stream
// carries the row and column of every cell that is not below any of its
// 4-neighbours, so plateaus count. Grid size is set on the cfg_ channel,
// register 0 for rows and 1 for columns, each clamped to 2..MAX_DIM; a write
// restarts the frame at row 0, column 0 and must be made while the block is idle,
// which the block itself does not enforce. Decisions for a row leave while the
// row below arrives; the last value of a frame also releases the decisions for
// the final row. out_tlast marks the last result caused by one input transaction.
// Timing: a first-row value is only stored; any other value passes the states
// for the two-port row store reads (centre, then sides), decide, emit and
// finish. The last value of a frame repeats the reads, decide and emit for each
// column of the last row. A four-entry queue lets input transactions be taken
// while the back end works, and the result register lets the back end go on
// while a result waits. When the receiver stalls, the back end waits only when
// a second result is ready; the queue then fills and in_tready falls.
// Reset clears positions, sizes (2 by 2) and all pending work; the row store
// needs no clearing, since every read whose value is used hits an entry written in the frame.
// Contents: top level; depends on glmf_pkg, glmf_front, glmf_fifo and glmf_back.
module grid_local_maximum_finder
  import glmf_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_INDEX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]      in_tdata,   // [VALUE_BITS-1:0] cell_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [OUT_DATA_W-1:0]                out_tdata,  // [4:0] peak_row, [9:5] peak_col
  output logic                                 out_tlast
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CTL_W = $bits(ctl_t);
  localparam int REC_W = CTL_W + 2 * CW + VALUE_BITS;

  logic                  f_valid, f_ready, b_valid, b_ready;
  ctl_t                  f_ctl, b_ctl;
  logic [CW-1:0]         f_row, f_col, b_row, b_col;
  logic [VALUE_BITS-1:0] f_value, b_value;
  logic [DW-1:0]         grid_cols;
  logic [REC_W-1:0]      q_in, q_out;

  glmf_front #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata[VALUE_BITS-1:0]),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec_ctl   (f_ctl),
    .rec_row   (f_row),
    .rec_col   (f_col),
    .rec_value (f_value),
    .grid_cols (grid_cols)
  );

  assign q_in = {f_ctl, f_row, f_col, f_value};

  glmf_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_in),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_out)
  );

  assign {b_ctl, b_row, b_col, b_value} = q_out;

  glmf_back #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (b_valid),
    .rec_ready  (b_ready),
    .rec_ctl    (b_ctl),
    .rec_row    (b_row),
    .rec_col    (b_col),
    .rec_value  (b_value),
    .grid_cols  (grid_cols),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/glmf_ram.sv =====
// Generic memory with one write port and two registered read ports.
// Used for the row store; depends on nothing else.
module glmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ===== rtl/core/glmf_fifo.sv =====
// Small register queue between the front end and the back end.
// Generic in width and depth; depends on nothing else.
module glmf_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/glmf_front.sv =====
// Front end: holds the grid size registers and the raster position, and
// classifies each accepted value into a record for the back end. Uses glmf_pkg.
module glmf_front
  import glmf_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [VALUE_BITS-1:0]          in_value,
  output logic                           rec_valid,
  input  logic                           rec_ready,
  output ctl_t                           rec_ctl,
  output logic [$clog2(MAX_DIM)-1:0]     rec_row,
  output logic [$clog2(MAX_DIM)-1:0]     rec_col,
  output logic [VALUE_BITS-1:0]          rec_value,
  output logic [$clog2(MAX_DIM+1)-1:0]   grid_cols
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  logic [DW-1:0] rows_r, rows_nxt;
  logic [DW-1:0] cols_r, cols_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  line_t         line_r, line_nxt;
  logic [DW-1:0] cfg_dim;
  logic          last_col, last_row, accept, cfg_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = rec_ready;
  assign rec_valid = in_valid;
  assign rec_value = in_value;
  assign rec_row   = row_r;
  assign rec_col   = col_r;
  assign grid_cols = cols_r;
  assign accept    = in_valid && rec_ready;
  assign last_col  = (DW'(col_r) + DW'(1) == cols_r);
  assign last_row  = (DW'(row_r) + DW'(1) == rows_r);
  assign cfg_hit   = cfg_valid && ((cfg_index == CFG_GRID_ROWS) || (cfg_index == CFG_GRID_COLS));

  always_comb begin
    if (cfg_data < CFG_DATA_W'(2)) begin
      cfg_dim = DW'(2);
    end else if (int'(cfg_data) > MAX_DIM) begin
      cfg_dim = DW'(MAX_DIM);
    end else begin
      cfg_dim = DW'(cfg_data);
    end
  end

  always_comb begin
    rec_ctl.decide = (row_r != '0);
    rec_ctl.above  = (row_r > CW'(1));
    rec_ctl.flush  = last_row && last_col;
    rec_ctl.line   = line_r;
  end

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    line_nxt = line_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt  = '0;
          line_nxt = LINE_FIRST;
        end else begin
          row_nxt  = CW'(row_r + 1'b1);
          line_nxt = line_next(line_r);
        end
      end else begin
        col_nxt = CW'(col_r + 1'b1);
      end
    end
    if (cfg_hit) begin
      if (cfg_index == CFG_GRID_ROWS) begin
        rows_nxt = cfg_dim;
      end else begin
        cols_nxt = cfg_dim;
      end
      row_nxt  = '0;
      col_nxt  = '0;
      line_nxt = LINE_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DW'(2);
      cols_r <= DW'(2);
      row_r  <= '0;
      col_r  <= '0;
      line_r <= LINE_FIRST;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

// ===== rtl/core/glmf_back.sv =====
// Back end: stores each value in the three-line row store, makes the
// neighbour comparisons and drives the result register. Uses glmf_pkg and glmf_ram.
module glmf_back
  import glmf_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rec_valid,
  output logic                          rec_ready,
  input  ctl_t                          rec_ctl,
  input  logic [$clog2(MAX_DIM)-1:0]    rec_row,
  input  logic [$clog2(MAX_DIM)-1:0]    rec_col,
  input  logic [VALUE_BITS-1:0]         rec_value,
  input  logic [$clog2(MAX_DIM+1)-1:0]  grid_cols,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_DATA_W-1:0]         out_tdata,
  output logic                          out_tlast
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int DEPTH = 3 * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PAD_W = OUT_DATA_W - OUT_ROW_W - OUT_COL_W;

  function automatic logic [AW-1:0] addr_of(line_t l, logic [CW-1:0] c);
    logic [AW-1:0] a;
    a = AW'(AW'(l) * AW'(MAX_DIM)) + AW'(c);
    return a;
  endfunction

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 row_r, row_nxt;
  line_t                         line_r, line_nxt;
  logic signed [VALUE_BITS-1:0]  val_r, val_nxt;
  logic                          flush_pend_r, flush_pend_nxt;
  logic                          flushing_r, flushing_nxt;
  logic [CW-1:0]                 op_row_r, op_row_nxt;
  logic [CW-1:0]                 op_col_r, op_col_nxt;
  line_t                         xl_r, xl_nxt;
  line_t                         yl_r, yl_nxt;
  logic                          above_ok_r, above_ok_nxt;
  logic                          below_ok_r, below_ok_nxt;
  logic signed [VALUE_BITS-1:0]  center_r, center_nxt;
  logic signed [VALUE_BITS-1:0]  above_r, above_nxt;
  logic                          peak_r, peak_nxt;
  logic                          held_valid_r, held_valid_nxt;
  logic [CW-1:0]                 held_row_r, held_row_nxt;
  logic [CW-1:0]                 held_col_r, held_col_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [CW-1:0]                 out_row_r, out_row_nxt;
  logic [CW-1:0]                 out_col_r, out_col_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [VALUE_BITS-1:0]         ram_rdata_a, ram_rdata_b;
  logic signed [VALUE_BITS-1:0]  left_v, right_v;
  logic                          left_ok, right_ok, more_cols, out_free, is_peak;
  logic [CW-1:0]                 left_col, right_col;

  glmf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (rec_value),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {PAD_W'(0), OUT_COL_W'(out_col_r), OUT_ROW_W'(out_row_r)};

  assign left_ok   = (op_col_r != '0);
  assign more_cols = (DW'(op_col_r) + DW'(1) < grid_cols);
  assign right_ok  = more_cols;
  assign left_col  = left_ok ? CW'(op_col_r - 1'b1) : op_col_r;
  assign right_col = right_ok ? CW'(op_col_r + 1'b1) : op_col_r;
  assign left_v    = $signed(ram_rdata_a);
  assign right_v   = $signed(ram_rdata_b);
  assign out_free  = !out_valid_r || out_tready;
  assign ram_waddr = addr_of(rec_ctl.line, rec_col);

  assign is_peak = !(above_ok_r && (center_r < above_r)) &&
                   !(below_ok_r && (center_r < val_r)) &&
                   !(left_ok && (center_r < left_v)) &&
                   !(right_ok && (center_r < right_v));

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    line_nxt       = line_r;
    val_nxt        = val_r;
    flush_pend_nxt = flush_pend_r;
    flushing_nxt   = flushing_r;
    op_row_nxt     = op_row_r;
    op_col_nxt     = op_col_r;
    xl_nxt         = xl_r;
    yl_nxt         = yl_r;
    above_ok_nxt   = above_ok_r;
    below_ok_nxt   = below_ok_r;
    center_nxt     = center_r;
    above_nxt      = above_r;
    peak_nxt       = peak_r;
    held_valid_nxt = held_valid_r;
    held_row_nxt   = held_row_r;
    held_col_nxt   = held_col_r;
    out_valid_nxt  = out_valid_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_last_nxt   = out_last_r;
    rec_ready      = 1'b0;
    ram_we         = 1'b0;
    ram_raddr_a    = addr_of(xl_r, op_col_r);
    ram_raddr_b    = addr_of(yl_r, op_col_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (rec_valid) begin
          rec_ready      = 1'b1;
          ram_we         = 1'b1;
          val_nxt        = $signed(rec_value);
          row_nxt        = rec_row;
          line_nxt       = rec_ctl.line;
          flush_pend_nxt = rec_ctl.flush;
          if (rec_ctl.decide) begin
            op_row_nxt   = CW'(rec_row - 1'b1);
            op_col_nxt   = rec_col;
            xl_nxt       = line_prev(rec_ctl.line);
            yl_nxt       = line_next(rec_ctl.line);
            above_ok_nxt = rec_ctl.above;
            below_ok_nxt = 1'b1;
            flushing_nxt = 1'b0;
            state_nxt    = ST_RD_CEN;
          end else if (rec_ctl.flush) begin
            op_row_nxt     = rec_row;
            op_col_nxt     = '0;
            xl_nxt         = rec_ctl.line;
            yl_nxt         = line_prev(rec_ctl.line);
            above_ok_nxt   = 1'b1;
            below_ok_nxt   = 1'b0;
            flushing_nxt   = 1'b1;
            flush_pend_nxt = 1'b0;
            state_nxt      = ST_RD_CEN;
          end
        end
      end
      ST_RD_CEN: begin
        state_nxt = ST_RD_SIDE;
      end
      ST_RD_SIDE: begin
        center_nxt  = $signed(ram_rdata_a);
        above_nxt   = $signed(ram_rdata_b);
        ram_raddr_a = addr_of(xl_r, left_col);
        ram_raddr_b = addr_of(xl_r, right_col);
        state_nxt   = ST_DECIDE;
      end
      ST_DECIDE: begin
        peak_nxt  = is_peak;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!peak_r || !held_valid_r || out_free) begin
          if (peak_r) begin
            if (held_valid_r) begin
              out_valid_nxt = 1'b1;
              out_row_nxt   = held_row_r;
              out_col_nxt   = held_col_r;
              out_last_nxt  = 1'b0;
            end
            held_valid_nxt = 1'b1;
            held_row_nxt   = op_row_r;
            held_col_nxt   = op_col_r;
          end
          if (!flushing_r && flush_pend_r) begin
            op_row_nxt     = row_r;
            op_col_nxt     = '0;
            xl_nxt         = line_r;
            yl_nxt         = line_prev(line_r);
            above_ok_nxt   = 1'b1;
            below_ok_nxt   = 1'b0;
            flushing_nxt   = 1'b1;
            flush_pend_nxt = 1'b0;
            state_nxt      = ST_RD_CEN;
          end else if (flushing_r && more_cols) begin
            op_col_nxt = CW'(op_col_r + 1'b1);
            state_nxt  = ST_RD_CEN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!held_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_row_nxt    = held_row_r;
          out_col_nxt    = held_col_r;
          out_last_nxt   = 1'b1;
          held_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flush_pend_r <= 1'b0;
      flushing_r   <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flush_pend_r <= flush_pend_nxt;
      flushing_r   <= flushing_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    line_r     <= line_nxt;
    val_r      <= val_nxt;
    op_row_r   <= op_row_nxt;
    op_col_r   <= op_col_nxt;
    xl_r       <= xl_nxt;
    yl_r       <= yl_nxt;
    above_ok_r <= above_ok_nxt;
    below_ok_r <= below_ok_nxt;
    center_r   <= center_nxt;
    above_r    <= above_nxt;
    peak_r     <= peak_nxt;
    held_row_r <= held_row_nxt;
    held_col_r <= held_col_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
